// File: rtl/core/erv_pkg.sv
// Package with shared types, constants and arithmetic helpers for the Euler vector rotator.
`timescale 1ns / 1ps
package erv_pkg;

	localparam int VEC_W = 32;
	localparam int ANG_W = 26;
	localparam int FRAC_BITS = 16;
	localparam int Q_W = 32;
	localparam int ACC_W = 34;
	localparam logic signed [Q_W-1:0] INV_GAIN_Q30 = 32'sd652032874;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic signed [Q_W-1:0] Q30_ONE = 32'sd1073741824;

	function automatic logic signed [ACC_W-1:0] atan_q30(input logic [4:0] idx);
		logic [ACC_W-1:0] r;
		begin
			case (idx)
				5'd0: r = 34'd843314857;
				5'd1: r = 34'd497837829;
				5'd2: r = 34'd263043837;
				5'd3: r = 34'd133525159;
				5'd4: r = 34'd67021687;
				5'd5: r = 34'd33543516;
				5'd6: r = 34'd16775851;
				5'd7: r = 34'd8388437;
				5'd8: r = 34'd4194283;
				5'd9: r = 34'd2097149;
				default: r = 34'd1073741824 >> idx;
			endcase
			return $signed(r);
		end
	endfunction

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
		logic flip;
	} cordic_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [VEC_W-1:0] vz;
	} vec_t;

	// Q30 product rounded half up, result truncated to the width of a sine.
	function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
			input logic signed [Q_W-1:0] b);
		logic signed [2*Q_W-1:0] p;
		begin
			p = a * b + 64'sd536870912;
			return Q_W'(p >>> 30);
		end
	endfunction

	function automatic logic signed [Q_W-1:0] clamp_unit(input logic signed [Q_W+1:0] v);
		begin
			if (v > 34'sd1073741824)
				return Q30_ONE;
			else if (v < -34'sd1073741824)
				return -Q30_ONE;
			else
				return Q_W'(v);
		end
	endfunction

endpackage

// File: rtl/core/erv_reduce.sv
// Angle reduction to a quarter turn and conversion from degrees to Q30 radians.
`timescale 1ns / 1ps
module erv_reduce
	import erv_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic signed [ANG_W-1:0] deg,
	input  logic negate,
	output cordic_t cell_out
);
	localparam int AW = ANG_W + 2;
	localparam logic signed [AW-1:0] HALF = AW'(180 * (2 ** FRAC_BITS));
	localparam logic signed [AW-1:0] FULL = AW'(360 * (2 ** FRAC_BITS));
	localparam logic signed [AW-1:0] QUAR = AW'(90 * (2 ** FRAC_BITS));
	localparam logic [63:0] HALF_U = 64'(180 * (2 ** FRAC_BITS));
	// The half turn is 45 * 2^QSH, so the rounding division is a shift followed by a
	// division by 45, done as a multiplication with the reciprocal scaled by 2^KSH.
	// The shifted numerator stays below 2^NW, for which this reciprocal is exact.
	localparam int QSH = FRAC_BITS + 2;
	localparam int NW = 37;
	localparam int KSH = 43;
	localparam logic [37:0] RECIP = 38'(((64'd1 << KSH) + 64'd44) / 64'd45);

	logic signed [AW-1:0] a_s1;
	logic signed [AW-1:0] r0, r1, r2;
	logic flip_c, flip_s1, sign_s1, flip_s2, sign_s2, flip_s3, sign_s3, flip_s4, sign_s4;
	logic [AW-1:0] mag_c;
	logic [AW-1:0] mag_s1;
	logic [63:0] num_s2;
	logic [NW-1:0] n_c;
	logic [37:0] pp_s3 [4];
	logic [75:0] sum_c;
	logic [31:0] rad_s4;
	logic [ACC_W-1:0] rad_c;

	// The input lies within 512 degrees each way, so two conditional steps each way reduce it.
	always_comb begin
		r0 = a_s1;
		if (r0 >= FULL)
			r0 = r0 - FULL;
		if (r0 >= FULL)
			r0 = r0 - FULL;
		if (r0 < 0)
			r0 = r0 + FULL;
		if (r0 < 0)
			r0 = r0 + FULL;
		r1 = (r0 >= HALF) ? r0 - FULL : r0;
		flip_c = 1'b0;
		r2 = r1;
		if (r1 > QUAR) begin
			r2 = HALF - r1;
			flip_c = 1'b1;
		end else if (r1 < -QUAR) begin
			r2 = -HALF - r1;
			flip_c = 1'b1;
		end
		mag_c = r2[AW-1] ? AW'(-r2) : AW'(r2);
	end

	// The product of the numerator and the reciprocal is split into four partial products.
	always_comb begin
		n_c = NW'(num_s2 >> QSH);
		sum_c = {pp_s3[0], 38'd0} + 76'({pp_s3[1], 19'd0}) + 76'({pp_s3[2], 19'd0})
			+ 76'(pp_s3[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= negate ? -AW'(deg) : AW'(deg);
			mag_s1 <= mag_c;
			flip_s1 <= flip_c;
			sign_s1 <= r2[AW-1];
			num_s2 <= 64'(mag_s1) * 64'(PI_Q30) + (HALF_U >> 1);
			flip_s2 <= flip_s1;
			sign_s2 <= sign_s1;
			pp_s3[0] <= 38'(n_c[36:19]) * 38'(RECIP[37:19]);
			pp_s3[1] <= 38'(n_c[36:19]) * 38'(RECIP[18:0]);
			pp_s3[2] <= 38'(n_c[18:0]) * 38'(RECIP[37:19]);
			pp_s3[3] <= 38'(n_c[18:0]) * 38'(RECIP[18:0]);
			flip_s3 <= flip_s2;
			sign_s3 <= sign_s2;
			rad_s4 <= 32'(sum_c >> KSH);
			flip_s4 <= flip_s3;
			sign_s4 <= sign_s3;
		end
	end

	// The quotient stays below 2^31.
	always_comb begin
		rad_c = ACC_W'(rad_s4);
		cell_out.x = ACC_W'(INV_GAIN_Q30);
		cell_out.y = '0;
		cell_out.z = sign_s4 ? -$signed(rad_c) : $signed(rad_c);
		cell_out.flip = flip_s4;
	end
endmodule

// File: rtl/core/erv_cordic_cell.sv
// One CORDIC rotation cell with its output register.
`timescale 1ns / 1ps
module erv_cordic_cell
	import erv_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic en,
	input  cordic_t cell_in,
	output cordic_t cell_out
);
	localparam logic [4:0] IDX5 = 5'(IDX);
	cordic_t nxt;
	logic signed [ACC_W-1:0] dx, dy, at;

	always_comb begin
		dx = cell_in.y >>> IDX;
		dy = cell_in.x >>> IDX;
		at = atan_q30(IDX5);
		nxt.flip = cell_in.flip;
		if (!cell_in.z[ACC_W-1]) begin
			nxt.x = cell_in.x - dx;
			nxt.y = cell_in.y + dy;
			nxt.z = cell_in.z - at;
		end else begin
			nxt.x = cell_in.x + dx;
			nxt.y = cell_in.y - dy;
			nxt.z = cell_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			cell_out <= nxt;
	end
endmodule

// File: rtl/core/erv_sincos.sv
// Angle reduction followed by a chain of CORDIC cells producing sine and cosine.
`timescale 1ns / 1ps
module erv_sincos
	import erv_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic en,
	input  logic signed [ANG_W-1:0] deg,
	input  logic negate,
	output logic signed [Q_W-1:0] sin_q,
	output logic signed [Q_W-1:0] cos_q
);
	cordic_t chain [CORDIC_STAGES+1];

	erv_reduce u_reduce (
		.clk(clk), .en(en), .deg(deg), .negate(negate), .cell_out(chain[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		erv_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk), .en(en), .cell_in(chain[i]), .cell_out(chain[i+1])
		);
	end

	assign sin_q = Q_W'(chain[CORDIC_STAGES].y);
	assign cos_q = chain[CORDIC_STAGES].flip ? Q_W'(-chain[CORDIC_STAGES].x)
		: Q_W'(chain[CORDIC_STAGES].x);
endmodule

// File: rtl/core/erv_matrix.sv
// Rotation matrix formation, matrix-vector product, rounding and saturation.
`timescale 1ns / 1ps
module erv_matrix
	import erv_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic signed [Q_W-1:0] sp, cp, sy, cy, sr, cr,
	input  vec_t vec,
	output logic signed [VEC_W-1:0] ox, oy, oz
);
	localparam int SW = 66;
	logic signed [Q_W-1:0] sp_s1, sr_s1, cr_s1;
	logic signed [Q_W-1:0] cysp_s1, sysp_s1, cycp_s1, sycp_s1, cpsr_s1, cpcr_s1;
	logic signed [Q_W-1:0] sycr_s1, sysr_s1, cycr_s1, cysr_s1;
	logic signed [Q_W-1:0] m [9];
	vec_t v1, v2;
	logic signed [63:0] p_s3 [9];
	logic signed [SW-1:0] rx_s4, ry_s4, rz_s4;

	function automatic logic signed [VEC_W-1:0] finish(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] v;
		begin
			v = (s + SW'(64'sd536870912)) >>> 30;
			if (v > SW'(64'sd2147483647))
				return 32'sh7fffffff;
			else if (v < -SW'(64'sd2147483648))
				return 32'sh80000000;
			else
				return VEC_W'(v);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s1 <= sp;
			sr_s1 <= sr;
			cr_s1 <= cr;
			cysp_s1 <= qmul(cy, sp);
			sysp_s1 <= qmul(sy, sp);
			cycp_s1 <= qmul(cy, cp);
			sycp_s1 <= qmul(sy, cp);
			cpsr_s1 <= qmul(cp, sr);
			cpcr_s1 <= qmul(cp, cr);
			sycr_s1 <= qmul(sy, cr);
			sysr_s1 <= qmul(sy, sr);
			cycr_s1 <= qmul(cy, cr);
			cysr_s1 <= qmul(cy, sr);
			v1 <= vec;
			m[0] <= clamp_unit(34'(cycp_s1));
			m[1] <= clamp_unit(34'(qmul(cysp_s1, sr_s1)) - 34'(sycr_s1));
			m[2] <= clamp_unit(34'(qmul(cysp_s1, cr_s1)) + 34'(sysr_s1));
			m[3] <= clamp_unit(34'(sycp_s1));
			m[4] <= clamp_unit(34'(qmul(sysp_s1, sr_s1)) + 34'(cycr_s1));
			m[5] <= clamp_unit(34'(qmul(sysp_s1, cr_s1)) - 34'(cysr_s1));
			m[6] <= clamp_unit(-34'(sp_s1));
			m[7] <= clamp_unit(34'(cpsr_s1));
			m[8] <= clamp_unit(34'(cpcr_s1));
			v2 <= v1;
			p_s3[0] <= v2.vx * m[0];
			p_s3[1] <= v2.vy * m[1];
			p_s3[2] <= v2.vz * m[2];
			p_s3[3] <= v2.vx * m[3];
			p_s3[4] <= v2.vy * m[4];
			p_s3[5] <= v2.vz * m[5];
			p_s3[6] <= v2.vx * m[6];
			p_s3[7] <= v2.vy * m[7];
			p_s3[8] <= v2.vz * m[8];
			rx_s4 <= SW'(p_s3[0]) + SW'(p_s3[1]) + SW'(p_s3[2]);
			ry_s4 <= -(SW'(p_s3[3]) + SW'(p_s3[4]) + SW'(p_s3[5]));
			rz_s4 <= SW'(p_s3[6]) + SW'(p_s3[7]) + SW'(p_s3[8]);
		end
	end

	assign ox = finish(rx_s4);
	assign oy = finish(ry_s4);
	assign oz = finish(rz_s4);
endmodule

// File: rtl/core/euler_rotate_vector.sv
// Top level of the Euler-angle vector rotator: a stream of vectors rotated by yaw, pitch, roll.
// Throughput: one request per clock; the whole datapath is a chain of cells that advances
// together whenever the output register can take a new result.
// Reset: arst_n clears the valid bits of the pipeline; the data registers are not reset.
`timescale 1ns / 1ps
module euler_rotate_vector
	import erv_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vec_x [31:0], vec_y [63:32], vec_z [95:64], pitch [121:96], yaw [147:122],
	// roll [173:148], zero fill [175:174]
	input  logic [175:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// out_x [31:0], out_y [63:32], out_z [95:64]
	output logic [95:0] m_tdata
);
	// Depth of the sine/cosine chain (five reduction stages) plus the four matrix stages.
	localparam int DEPTH = CORDIC_STAGES + 5 + 4;

	logic [DEPTH-1:0] vld_q;
	logic en;
	logic signed [Q_W-1:0] sp, cp, sy, cy, sr, cr;
	vec_t vec_in, vec_d;
	vec_t vdly [CORDIC_STAGES+5];
	logic signed [VEC_W-1:0] ox, oy, oz;

	// The pipeline advances whenever the last stage is empty or is being drained.
	assign en = !vld_q[DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[DEPTH-1];
	assign m_tdata = {oz, oy, ox};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	assign vec_in.vx = s_tdata[31:0];
	assign vec_in.vy = s_tdata[63:32];
	assign vec_in.vz = s_tdata[95:64];

	// The vector rides alongside the angle chain until the matrix is ready.
	always_ff @(posedge clk) begin
		if (en) begin
			vdly[0] <= vec_in;
			for (int i = 1; i < CORDIC_STAGES + 5; i++)
				vdly[i] <= vdly[i-1];
		end
	end
	assign vec_d = vdly[CORDIC_STAGES+4];

	// Pitch and yaw are negated before the sine and cosine are taken.
	erv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .deg(s_tdata[121:96]), .negate(1'b1), .sin_q(sp), .cos_q(cp)
	);
	erv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .deg(s_tdata[147:122]), .negate(1'b1), .sin_q(sy), .cos_q(cy)
	);
	erv_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .deg(s_tdata[173:148]), .negate(1'b0), .sin_q(sr), .cos_q(cr)
	);

	erv_matrix u_matrix (
		.clk(clk), .en(en), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
		.vec(vec_d), .ox(ox), .oy(oy), .oz(oz)
	);
endmodule

// File: rtl/core/erv_checker.sv
// Port-level checker for the Euler vector rotator and its bind statement.
`timescale 1ns / 1ps
module erv_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [95:0] m_tdata
);
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input stalled with empty output");
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready) else $error("input stalled while output drains");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_no_reset_out: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid) else $error("result after reset");
endmodule

bind euler_rotate_vector erv_checker u_erv_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
